/* hw/rtl/marching_squares_case_index_defines.svh */
// Assertion macros used by the top-level RTL module.
`ifndef MARCHING_SQUARES_CASE_INDEX_DEFINES_SVH
`define MARCHING_SQUARES_CASE_INDEX_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define MSCI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define MSCI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/msci_pkg.sv */
package msci_pkg;

	localparam int MAX_DIM         = 2048;
	localparam int GRID_LINE_DEPTH = 1025;

	localparam int DIM_W     = 12;
	localparam int PIX_W     = $clog2(MAX_DIM);
	localparam int STEP_W    = 7;
	localparam int THR_W     = 8;
	localparam int COLOR_W   = 8;
	localparam int SUM_W     = COLOR_W + 2;
	localparam int GRID_W    = $clog2(MAX_DIM / 2 + 2);
	localparam int LINE_AW   = $clog2(GRID_LINE_DEPTH);
	localparam int CELL_W    = 10;
	localparam int CASE_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int DIV_W     = DIM_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COL_STEP   = 3'd4;

	localparam logic [THR_W-1:0]  THRESHOLD_RESET = 8'd200;
	localparam logic [DIM_W-1:0]  DIM_RESET       = 12'd2048;
	localparam logic [STEP_W-1:0] STEP_RESET      = 7'd8;
	localparam logic [DIM_W-1:0]  DIM_MIN         = 12'd2;
	localparam logic [DIM_W-1:0]  DIM_MAX         = DIM_W'(MAX_DIM);
	localparam logic [STEP_W-1:0] STEP_MIN        = 7'd2;

	typedef enum logic [2:0] {
		CFG_IDLE,
		CFG_START,
		CFG_ROWS,
		CFG_COLS,
		CFG_PCOL
	} msci_cfg_state_t;

	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic [DIM_W-1:0]  rows;
		logic [DIM_W-1:0]  cols;
		logic [STEP_W-1:0] rs;
		logic [STEP_W-1:0] cs;
		logic [GRID_W-1:0] p;
		logic [GRID_W-1:0] q;
	} msci_geom_t;

	typedef struct packed {
		logic              valid;
		logic [STEP_W-1:0] col_phase;
		logic [GRID_W-1:0] col_grid;
	} msci_reload_t;

endpackage

/* hw/rtl/marching_squares_case_index.sv */
// Marching squares case classifier: takes one RGB pixel per cycle in raster order, unless the
// input is stalled, and emits the 4-bit case index of each grid cell when its lower-right grid
// point arrives. One row of grid bits lives in a single-port-per-direction line memory: a grid
// point reads its entry when the pixel transfer completes and writes it back as it leaves the
// grid point stage, where it waits while the result register is held, so the sustained rate is
// one pixel per clock while no stall is raised. After reset and after every configuration
// write the pixel input stalls while a shared bit-serial divider derives the grid size from
// the image size and steps and realigns the column counters.
// The line memory needs no clearing pass.
`include "marching_squares_case_index_defines.svh"

module marching_squares_case_index
	import msci_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COLOR_W-1:0]    red,
	input  logic [COLOR_W-1:0]    green,
	input  logic [COLOR_W-1:0]    blue,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CASE_W-1:0]     case_index,
	output logic [CELL_W-1:0]     cell_row,
	output logic [CELL_W-1:0]     cell_col,
	output logic                  last_cell
);

	msci_geom_t        geom;
	msci_reload_t      reload;
	logic              cfg_busy;

	logic [PIX_W-1:0]  pix_row_q;
	logic [PIX_W-1:0]  pix_col_q;
	logic [GRID_W-1:0] grid_row_q;
	logic [DIM_W-1:0]  row_target_q;
	logic [STEP_W-1:0] col_phase_q;
	logic [GRID_W-1:0] col_grid_q;

	logic              last_col;
	logic              col_wrap;
	logic              row_wrap;
	logic              grid_col;
	logic              grid_row;
	logic              grid_pt;
	logic [GRID_W-1:0] j;
	logic              accept;
	logic              rd_en;
	logic [SUM_W-1:0]  sum;
	logic [GRID_W+STEP_W-1:0] target_prod;

	logic              valid_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic [GRID_W-1:0] j_s1;
	logic [GRID_W-1:0] g_s1;
	logic              corner_s1;
	logic              emit_s1;

	logic [SUM_W-1:0]  thr_lim;
	logic              up;
	logic              bit_s2;
	logic              adv;
	logic              ul_q;
	logic              ll_q;
	logic              out_valid_q;
	logic [CASE_W-1:0] case_q;
	logic [CELL_W-1:0] cell_row_q;
	logic [CELL_W-1:0] cell_col_q;
	logic              last_q;

	msci_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_col (pix_col_q),
		.geom      (geom),
		.reload    (reload),
		.busy      (cfg_busy)
	);

	msci_line_mem u_line (
		.clk   (clk),
		.we    (adv),
		.waddr (j_s1[LINE_AW-1:0]),
		.wdata (bit_s2),
		.re    (rd_en),
		.raddr (j[LINE_AW-1:0]),
		.rdata (up)
	);

	// Position decode for the pixel at the input.
	assign last_col = ({1'b0, pix_col_q} == (geom.cols - 1'b1));
	assign col_wrap = (({1'b0, pix_col_q} + 1'b1) >= geom.cols);
	assign row_wrap = (({1'b0, pix_row_q} + 1'b1) >= geom.rows);
	assign grid_col = last_col || ((col_phase_q == '0) && (col_grid_q < geom.q));
	assign j        = last_col ? geom.q : col_grid_q;

	always_comb begin
		if (grid_row_q < geom.p) begin
			grid_row = ({1'b0, pix_row_q} == row_target_q);
		end else if (grid_row_q == geom.p) begin
			grid_row = ({1'b0, pix_row_q} == (geom.rows - 1'b1));
		end else begin
			grid_row = 1'b0;
		end
	end

	assign grid_pt  = grid_row && grid_col &&
		({{(DIM_W-GRID_W){1'b0}}, j} < DIM_W'(GRID_LINE_DEPTH));
	assign in_stall = cfg_busy || cfg_we || (valid_s1 && out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign rd_en    = accept && grid_pt;
	assign sum      = {2'b0, red} + {2'b0, green} + {2'b0, blue};
	assign target_prod = grid_row_q * geom.rs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_row_q    <= '0;
			pix_col_q    <= '0;
			grid_row_q   <= '0;
			row_target_q <= '0;
			col_phase_q  <= '0;
			col_grid_q   <= '0;
		end else if (reload.valid) begin
			col_phase_q  <= reload.col_phase;
			col_grid_q   <= reload.col_grid;
			row_target_q <= target_prod[DIM_W-1:0];
		end else if (accept) begin
			if (col_wrap) begin
				pix_col_q   <= '0;
				col_phase_q <= '0;
				col_grid_q  <= '0;
				if (row_wrap) begin
					pix_row_q    <= '0;
					grid_row_q   <= '0;
					row_target_q <= '0;
				end else begin
					pix_row_q <= pix_row_q + 1'b1;
					if (grid_row) begin
						grid_row_q   <= grid_row_q + 1'b1;
						row_target_q <= row_target_q + {{(DIM_W-STEP_W){1'b0}}, geom.rs};
					end
				end
			end else begin
				pix_col_q <= pix_col_q + 1'b1;
				if ((col_phase_q + 1'b1) == geom.cs) begin
					col_phase_q <= '0;
					col_grid_q  <= col_grid_q + 1'b1;
				end else begin
					col_phase_q <= col_phase_q + 1'b1;
				end
			end
		end
	end

	// Grid point stage: holds a grid point with its line memory read data while the result register is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= grid_pt;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sum_s1    <= sum;
			j_s1      <= j;
			g_s1      <= grid_row_q;
			corner_s1 <= (grid_row_q == geom.p) && (j == geom.q);
			emit_s1   <= (j != '0) && (grid_row_q != '0);
		end
	end

	assign thr_lim = ({2'b0, geom.threshold} << 1) + {2'b0, geom.threshold} + 2'd2;
	assign bit_s2  = !corner_s1 && (sum_s1 <= thr_lim);
	assign adv     = valid_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q        <= 1'b0;
			ll_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				ul_q <= up;
				ll_q <= bit_s2;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= adv && emit_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_s1) begin
			case_q     <= {ul_q, up, bit_s2, ll_q};
			cell_row_q <= CELL_W'(g_s1 - 1'b1);
			cell_col_q <= CELL_W'(j_s1 - 1'b1);
			last_q     <= corner_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign case_index = case_q;
	assign cell_row   = cell_row_q;
	assign cell_col   = cell_col_q;
	assign last_cell  = last_q;

	`MSCI_ASSERT_IMP(a_line_no_collide, rd_en && adv, j != j_s1, "line read and write hit one entry")
	`MSCI_ASSERT_IMP(a_hold_no_read, valid_s1 && !adv, !rd_en, "line read while a grid point waits")
	`MSCI_ASSERT_IMP(a_last_corner_zero, out_valid && last_cell, !case_index[1], "corner bit set")
	`MSCI_ASSERT_NEXT(a_emit_shows, adv && emit_s1, out_valid, "emitted cell not presented")

endmodule

/* hw/rtl/msci_div.sv */
module msci_div
	import msci_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [STEP_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient,
	output logic [STEP_W-1:0] remainder
);

	logic [DIV_W-1:0]     dvd_q;
	logic [STEP_W-1:0]    rem_q;
	logic [STEP_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [STEP_W:0]      trial;
	logic [STEP_W:0]      diff;
	logic                 ge;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

/* hw/rtl/msci_cfg.sv */
module msci_cfg
	import msci_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [PIX_W-1:0]      pixel_col,
	output msci_geom_t            geom,
	output msci_reload_t          reload,
	output logic                  busy
);

	msci_cfg_state_t   state_q, state_d;
	logic [THR_W-1:0]  threshold_q;
	logic [DIM_W-1:0]  image_rows_q;
	logic [DIM_W-1:0]  image_cols_q;
	logic [STEP_W-1:0] row_step_q;
	logic [STEP_W-1:0] col_step_q;
	logic [GRID_W-1:0] p_q;
	logic [GRID_W-1:0] q_q;
	logic [DIM_W-1:0]  rows;
	logic [DIM_W-1:0]  cols;
	logic [STEP_W-1:0] rs;
	logic [STEP_W-1:0] cs;
	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [STEP_W-1:0] div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [STEP_W-1:0] div_rem;
	logic              load_p;
	logic              load_q;
	logic              reload_valid;

	assign rows = (image_rows_q < DIM_MIN) ? DIM_MIN :
		(image_rows_q > DIM_MAX) ? DIM_MAX : image_rows_q;
	assign cols = (image_cols_q < DIM_MIN) ? DIM_MIN :
		(image_cols_q > DIM_MAX) ? DIM_MAX : image_cols_q;
	assign rs = (row_step_q < STEP_MIN) ? STEP_MIN : row_step_q;
	assign cs = (col_step_q < STEP_MIN) ? STEP_MIN : col_step_q;

	msci_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RESET;
			image_rows_q <= DIM_RESET;
			image_cols_q <= DIM_RESET;
			row_step_q   <= STEP_RESET;
			col_step_q   <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:  threshold_q  <= cfg_data[THR_W-1:0];
				REG_IMAGE_ROWS: image_rows_q <= cfg_data[DIM_W-1:0];
				REG_IMAGE_COLS: image_cols_q <= cfg_data[DIM_W-1:0];
				REG_ROW_STEP:   row_step_q   <= cfg_data[STEP_W-1:0];
				REG_COL_STEP:   col_step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CFG_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_p) begin
			p_q <= div_quo[GRID_W-1:0];
		end
		if (load_q) begin
			q_q <= div_quo[GRID_W-1:0];
		end
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = rows;
		div_divisor  = cs;
		load_p       = 1'b0;
		load_q       = 1'b0;
		reload_valid = 1'b0;
		unique case (state_q)
			CFG_IDLE: ;
			CFG_START: begin
				div_start    = 1'b1;
				div_dividend = rows;
				div_divisor  = rs;
				state_d      = CFG_ROWS;
			end
			CFG_ROWS: begin
				div_divisor = rs;
				if (div_done) begin
					load_p       = 1'b1;
					div_start    = 1'b1;
					div_dividend = cols;
					div_divisor  = cs;
					state_d      = CFG_COLS;
				end
			end
			CFG_COLS: begin
				if (div_done) begin
					load_q       = 1'b1;
					div_start    = 1'b1;
					div_dividend = {1'b0, pixel_col};
					state_d      = CFG_PCOL;
				end
			end
			CFG_PCOL: begin
				if (div_done) begin
					reload_valid = 1'b1;
					state_d      = CFG_IDLE;
				end
			end
		endcase
		if (cfg_we) begin
			state_d      = CFG_START;
			div_start    = 1'b0;
			load_p       = 1'b0;
			load_q       = 1'b0;
			reload_valid = 1'b0;
		end
	end

	assign geom.threshold = threshold_q;
	assign geom.rows      = rows;
	assign geom.cols      = cols;
	assign geom.rs        = rs;
	assign geom.cs        = cs;
	assign geom.p         = p_q;
	assign geom.q         = q_q;

	assign reload.valid     = reload_valid;
	assign reload.col_phase = div_rem;
	assign reload.col_grid  = div_quo[GRID_W-1:0];

	assign busy = (state_q != CFG_IDLE);

endmodule

/* hw/rtl/msci_line_mem.sv */
module msci_line_mem
	import msci_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [LINE_AW-1:0] waddr,
	input  logic               wdata,
	input  logic               re,
	input  logic [LINE_AW-1:0] raddr,
	output logic               rdata
);

	logic mem_q [GRID_LINE_DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
